@@ src/tose_pkg.sv @@
// Shared types, constants and the microcode table of the Taylor ODE step engine.
// No dependencies; used by tose_mul, taylor_ode_step_engine and the bench files.
package tose_pkg;

    // Fixed widths of the interface fields and the intermediate word.
    localparam int VAL_W        = 48;
    localparam int ACC_W        = 64;
    localparam int H_BITS       = 32;
    localparam int STEP_INDEX_W = 24;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 48;
    localparam int PC_W         = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_TIME    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VALUE = 2'd2;

    // Register reset values.
    localparam logic [H_BITS-1:0] STEP_SIZE_RST     = 32'd844677;
    localparam logic [VAL_W-1:0]  START_TIME_RST    = 48'd4294967296;
    localparam logic [VAL_W-1:0]  INITIAL_VALUE_RST = 48'd879022680;

    // Reciprocals for floor(h/3) = (h*R3) >> 33 and floor(h/5) = (h*R5) >> 34.
    localparam logic [ACC_W-1:0] RECIP3 = 64'h0000_0000_AAAA_AAAB;
    localparam logic [ACC_W-1:0] RECIP5 = 64'h0000_0000_CCCC_CCCD;

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_MUL, OP_ADD, OP_BRST, OP_JMP, OP_LOAD, OP_CLAMP, OP_TIME, OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        SRC_V, SRC_D1, SRC_D2, SRC_D3, SRC_D4, SRC_D5, SRC_P, SRC_T,
        SRC_H, SRC_H2, SRC_H3, SRC_H4, SRC_H5, SRC_R3, SRC_R5
    } src_t;

    typedef enum logic [3:0] {
        DST_T, DST_P, DST_D1, DST_D2, DST_D3, DST_D4, DST_D5, DST_H3, DST_H5
    } dst_t;

    // Product shift: fraction bits, the h format, and the two reciprocal shifts.
    typedef enum logic [1:0] {
        SH_FRAC, SH_H, SH_33, SH_34
    } sh_t;

    // Exact integer scale applied after the product.
    typedef enum logic [1:0] {
        K1, K2, K6, K8
    } k_t;

    typedef struct packed {
        op_t             op;
        src_t            a;
        src_t            b;
        dst_t            dst;
        sh_t             sh;
        k_t              k;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic start;
        sh_t  sh;
        k_t   k;
    } mul_req_t;

    typedef struct packed {
        logic done;
        logic sat;
    } mul_rsp_t;

    localparam logic [PC_W-1:0] PC_TIME = 6'd32;
    localparam logic [PC_W-1:0] PC_RST  = 6'd34;

    function automatic ucode_t uop(input op_t op, input src_t a, input src_t b,
                                   input dst_t dst, input sh_t sh, input k_t k,
                                   input logic [PC_W-1:0] target);
        ucode_t w;
        w.op     = op;
        w.a      = a;
        w.b      = b;
        w.dst    = dst;
        w.sh     = sh;
        w.k      = k;
        w.target = target;
        return w;
    endfunction

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            6'd0:  w = uop(OP_BRST,  SRC_V,  SRC_V,  DST_T,  SH_FRAC, K1, PC_RST);
            // h/3 and h/5 through the shared multiplier
            6'd1:  w = uop(OP_MUL,   SRC_H,  SRC_R3, DST_H3, SH_33,   K1, '0);
            6'd2:  w = uop(OP_MUL,   SRC_H,  SRC_R5, DST_H5, SH_34,   K1, '0);
            // d1 = v + v*v
            6'd3:  w = uop(OP_MUL,   SRC_V,  SRC_V,  DST_T,  SH_FRAC, K1, '0);
            6'd4:  w = uop(OP_ADD,   SRC_V,  SRC_T,  DST_D1, SH_FRAC, K1, '0);
            // d2 = d1 + 2*v*d1
            6'd5:  w = uop(OP_MUL,   SRC_V,  SRC_D1, DST_T,  SH_FRAC, K2, '0);
            6'd6:  w = uop(OP_ADD,   SRC_D1, SRC_T,  DST_D2, SH_FRAC, K1, '0);
            // d3 = (d2 + 2*v*d2) + 2*d1*d1
            6'd7:  w = uop(OP_MUL,   SRC_V,  SRC_D2, DST_T,  SH_FRAC, K2, '0);
            6'd8:  w = uop(OP_ADD,   SRC_D2, SRC_T,  DST_D3, SH_FRAC, K1, '0);
            6'd9:  w = uop(OP_MUL,   SRC_D1, SRC_D1, DST_T,  SH_FRAC, K2, '0);
            6'd10: w = uop(OP_ADD,   SRC_D3, SRC_T,  DST_D3, SH_FRAC, K1, '0);
            // d4 = (d3 + 2*v*d3) + 6*d1*d2
            6'd11: w = uop(OP_MUL,   SRC_V,  SRC_D3, DST_T,  SH_FRAC, K2, '0);
            6'd12: w = uop(OP_ADD,   SRC_D3, SRC_T,  DST_D4, SH_FRAC, K1, '0);
            6'd13: w = uop(OP_MUL,   SRC_D1, SRC_D2, DST_T,  SH_FRAC, K6, '0);
            6'd14: w = uop(OP_ADD,   SRC_D4, SRC_T,  DST_D4, SH_FRAC, K1, '0);
            // d5 = (d4 + 2*v*d4) + (6*d2*d2 + 8*d1*d3)
            6'd15: w = uop(OP_MUL,   SRC_V,  SRC_D4, DST_T,  SH_FRAC, K2, '0);
            6'd16: w = uop(OP_ADD,   SRC_D4, SRC_T,  DST_D5, SH_FRAC, K1, '0);
            6'd17: w = uop(OP_MUL,   SRC_D2, SRC_D2, DST_T,  SH_FRAC, K6, '0);
            6'd18: w = uop(OP_MUL,   SRC_D1, SRC_D3, DST_P,  SH_FRAC, K8, '0);
            6'd19: w = uop(OP_ADD,   SRC_T,  SRC_P,  DST_T,  SH_FRAC, K1, '0);
            6'd20: w = uop(OP_ADD,   SRC_D5, SRC_T,  DST_D5, SH_FRAC, K1, '0);
            // Horner in h/5 .. h
            6'd21: w = uop(OP_MUL,   SRC_D5, SRC_H5, DST_T,  SH_H,    K1, '0);
            6'd22: w = uop(OP_ADD,   SRC_D4, SRC_T,  DST_P,  SH_FRAC, K1, '0);
            6'd23: w = uop(OP_MUL,   SRC_P,  SRC_H4, DST_T,  SH_H,    K1, '0);
            6'd24: w = uop(OP_ADD,   SRC_D3, SRC_T,  DST_P,  SH_FRAC, K1, '0);
            6'd25: w = uop(OP_MUL,   SRC_P,  SRC_H3, DST_T,  SH_H,    K1, '0);
            6'd26: w = uop(OP_ADD,   SRC_D2, SRC_T,  DST_P,  SH_FRAC, K1, '0);
            6'd27: w = uop(OP_MUL,   SRC_P,  SRC_H2, DST_T,  SH_H,    K1, '0);
            6'd28: w = uop(OP_ADD,   SRC_D1, SRC_T,  DST_P,  SH_FRAC, K1, '0);
            6'd29: w = uop(OP_MUL,   SRC_P,  SRC_H,  DST_T,  SH_H,    K1, '0);
            6'd30: w = uop(OP_ADD,   SRC_V,  SRC_T,  DST_P,  SH_FRAC, K1, '0);
            6'd31: w = uop(OP_CLAMP, SRC_P,  SRC_P,  DST_T,  SH_FRAC, K1, '0);
            // common tail: time, then the result word
            6'd32: w = uop(OP_TIME,  SRC_V,  SRC_V,  DST_T,  SH_FRAC, K1, '0);
            6'd33: w = uop(OP_EMIT,  SRC_V,  SRC_V,  DST_T,  SH_FRAC, K1, '0);
            // restart path
            6'd34: w = uop(OP_LOAD,  SRC_V,  SRC_V,  DST_T,  SH_FRAC, K1, '0);
            6'd35: w = uop(OP_JMP,   SRC_V,  SRC_V,  DST_T,  SH_FRAC, K1, PC_TIME);
            default: w = uop(OP_EMIT, SRC_V, SRC_V,  DST_T,  SH_FRAC, K1, '0);
        endcase
        return w;
    endfunction

endpackage

@@ src/tose_mul.sv @@
// Multi-cycle signed 64x64 multiplier with shift, saturation and small integer scale.
// Depends on tose_pkg; one 33x33 partial product per cycle.
module tose_mul #(
    parameter int FRACTION_BITS = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tose_pkg::mul_req_t          req,
    input  logic [tose_pkg::ACC_W-1:0]  a,
    input  logic [tose_pkg::ACC_W-1:0]  b,
    output tose_pkg::mul_rsp_t          rsp,
    output logic [tose_pkg::ACC_W-1:0]  result
);

    localparam int AW = tose_pkg::ACC_W;
    localparam int PW = 2 * AW;
    localparam int HW = AW / 2;

    logic              busy_reg;
    logic [2:0]        ph_reg;
    logic              done_reg;
    logic              sat_reg;
    logic [AW-1:0]     a_reg, b_reg;
    tose_pkg::sh_t     sh_reg;
    tose_pkg::k_t      k_reg;
    logic [2*HW+1:0]   prod_reg;
    logic [PW-1:0]     acc_reg;
    logic [AW-1:0]     mid_reg;
    logic [AW-1:0]     res_reg;

    logic signed [HW:0]     opa, opb;
    logic signed [2*HW+1:0] pp;
    logic [PW-1:0]          addend;
    logic [PW-1:0]          shd;
    logic                   shd_ov;
    logic [AW+3:0]          x_ext, scaled;
    logic                   sc_ov;

    // phases 0..3 pick the halves: low*low, low*high, high*low, high*high
    assign opa = ph_reg[1] ? $signed({a_reg[AW-1], a_reg[AW-1:HW]})
                           : $signed({1'b0, a_reg[HW-1:0]});
    assign opb = ph_reg[0] ? $signed({b_reg[AW-1], b_reg[AW-1:HW]})
                           : $signed({1'b0, b_reg[HW-1:0]});
    assign pp  = opa * opb;

    always_comb begin
        addend = {{(PW-2*HW-2){prod_reg[2*HW+1]}}, prod_reg};
        case (ph_reg)
            3'd1:       addend = addend;
            3'd2, 3'd3: addend = addend << HW;
            3'd4:       addend = addend << AW;
            default:    addend = '0;
        endcase
    end

    always_comb begin
        case (sh_reg)
            tose_pkg::SH_FRAC: shd = PW'($signed(acc_reg) >>> FRACTION_BITS);
            tose_pkg::SH_H:    shd = PW'($signed(acc_reg) >>> tose_pkg::H_BITS);
            tose_pkg::SH_33:   shd = PW'($signed(acc_reg) >>> 33);
            tose_pkg::SH_34:   shd = PW'($signed(acc_reg) >>> 34);
            default:           shd = acc_reg;
        endcase
        shd_ov = !((&shd[PW-1:AW-1]) || !(|shd[PW-1:AW-1]));
    end

    always_comb begin
        x_ext = {{4{mid_reg[AW-1]}}, mid_reg};
        case (k_reg)
            tose_pkg::K1: scaled = x_ext;
            tose_pkg::K2: scaled = x_ext << 1;
            tose_pkg::K6: scaled = (x_ext << 2) + (x_ext << 1);
            tose_pkg::K8: scaled = x_ext << 3;
            default:      scaled = x_ext;
        endcase
        sc_ov = !((&scaled[AW+3:AW-1]) || !(|scaled[AW+3:AW-1]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ph_reg   <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg) begin
                if (req.start) begin
                    busy_reg <= 1'b1;
                    ph_reg   <= '0;
                end
            end else begin
                ph_reg <= ph_reg + 3'd1;
                if (ph_reg == 3'd6) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!busy_reg && req.start) begin
            a_reg   <= a;
            b_reg   <= b;
            sh_reg  <= req.sh;
            k_reg   <= req.k;
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (ph_reg <= 3'd3) begin
                prod_reg <= pp;
            end
            if (ph_reg >= 3'd1 && ph_reg <= 3'd4) begin
                acc_reg <= acc_reg + addend;
            end
            if (ph_reg == 3'd5) begin
                mid_reg <= shd_ov ? (acc_reg[PW-1] ? tose_pkg::ACC_MIN : tose_pkg::ACC_MAX)
                                  : shd[AW-1:0];
                sat_reg <= shd_ov;
            end
            if (ph_reg == 3'd6) begin
                res_reg <= sc_ov ? (mid_reg[AW-1] ? tose_pkg::ACC_MIN : tose_pkg::ACC_MAX)
                                 : scaled[AW-1:0];
                sat_reg <= sat_reg | sc_ov;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.sat  = sat_reg;
    assign result   = res_reg;

endmodule

@@ src/taylor_ode_step_engine.sv @@
// Taylor ODE step engine: order-5 Taylor step for x' = x + x^2 in signed fixed point.
// Throughput: one word in flight; each of the 16 products runs on the shared
//   multi-cycle multiplier (tose_mul), which stalls the sequencer until the product is done.
// Reset: synchronous active-low aresetn loads register reset values, x from initial value,
//   clears the step count; a new word is taken while a finished result still waits.
module taylor_ode_step_engine #(
    parameter int FRACTION_BITS    = 32,
    parameter int STEP_COUNT_WIDTH = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [tose_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tose_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    // input words
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_restart,
    // result words
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [tose_pkg::STEP_INDEX_W-1:0]    m_step_index,
    output logic signed [tose_pkg::VAL_W-1:0]    m_time_value,
    output logic signed [tose_pkg::VAL_W-1:0]    m_solution_value,
    output logic                                 m_overflow
);

    localparam int AW   = tose_pkg::ACC_W;
    localparam int VW   = tose_pkg::VAL_W;
    localparam int HB   = tose_pkg::H_BITS;
    localparam int PCW  = tose_pkg::PC_W;
    localparam int KH_W = STEP_COUNT_WIDTH + HB;
    localparam int UP   = (FRACTION_BITS >= HB) ? FRACTION_BITS - HB : 0;
    localparam int DN   = (FRACTION_BITS < HB) ? HB - FRACTION_BITS : 0;
    localparam int TW   = KH_W + UP + 2;
    localparam logic [STEP_COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // configuration
    logic [HB-1:0]  step_size_reg;
    logic [VW-1:0]  start_time_reg;
    logic [VW-1:0]  initial_value_reg;

    // sequencer
    logic                  busy_reg;
    logic [PCW-1:0]        pc_reg, pc_next;
    logic                  restart_reg;
    logic                  pend_reg;
    logic                  hit_reg;
    tose_pkg::ucode_t      uw;

    // solution state and datapath
    logic [AW-1:0]               v_reg;
    logic [STEP_COUNT_WIDTH-1:0] count_reg;
    logic [AW-1:0] d1_reg, d2_reg, d3_reg, d4_reg, d5_reg, p_reg, t_reg, h3_reg, h5_reg;
    logic [KH_W-1:0]             kh_reg;

    // result register
    logic m_valid_reg;

    logic [AW-1:0] a_val, b_val, h_ext;
    logic [AW:0]   add_sum;
    logic          add_ov;
    logic [AW-1:0] add_res;
    logic          clamp_ov;
    logic [AW-1:0] clamp_res;
    logic [TW-1:0] t_scaled, t_sum;
    logic          t_ov;
    logic [VW-1:0] t_res;

    logic accept, out_free, mul_fire, mul_take, add_do, emit_do, wr_en;
    logic [AW-1:0] wr_data;

    tose_pkg::mul_req_t mreq;
    tose_pkg::mul_rsp_t mrsp;
    logic [AW-1:0]      mul_res;

    assign uw       = tose_pkg::ucode_rom(pc_reg);
    assign s_ready  = !busy_reg;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign mul_fire = busy_reg && (uw.op == tose_pkg::OP_MUL) && !pend_reg;
    assign mul_take = busy_reg && (uw.op == tose_pkg::OP_MUL) && pend_reg && mrsp.done;
    assign add_do   = busy_reg && (uw.op == tose_pkg::OP_ADD);
    assign emit_do  = busy_reg && (uw.op == tose_pkg::OP_EMIT) && out_free;
    assign wr_en    = mul_take || add_do;
    assign wr_data  = mul_take ? mul_res : add_res;
    assign h_ext    = AW'(step_size_reg);

    // Operand selection for both read ports.
    always_comb begin
        case (uw.a)
            tose_pkg::SRC_V:  a_val = v_reg;
            tose_pkg::SRC_D1: a_val = d1_reg;
            tose_pkg::SRC_D2: a_val = d2_reg;
            tose_pkg::SRC_D3: a_val = d3_reg;
            tose_pkg::SRC_D4: a_val = d4_reg;
            tose_pkg::SRC_D5: a_val = d5_reg;
            tose_pkg::SRC_P:  a_val = p_reg;
            tose_pkg::SRC_T:  a_val = t_reg;
            tose_pkg::SRC_H:  a_val = h_ext;
            tose_pkg::SRC_H2: a_val = h_ext >> 1;
            tose_pkg::SRC_H3: a_val = h3_reg;
            tose_pkg::SRC_H4: a_val = h_ext >> 2;
            tose_pkg::SRC_H5: a_val = h5_reg;
            tose_pkg::SRC_R3: a_val = tose_pkg::RECIP3;
            tose_pkg::SRC_R5: a_val = tose_pkg::RECIP5;
            default:          a_val = '0;
        endcase
    end

    always_comb begin
        case (uw.b)
            tose_pkg::SRC_V:  b_val = v_reg;
            tose_pkg::SRC_D1: b_val = d1_reg;
            tose_pkg::SRC_D2: b_val = d2_reg;
            tose_pkg::SRC_D3: b_val = d3_reg;
            tose_pkg::SRC_D4: b_val = d4_reg;
            tose_pkg::SRC_D5: b_val = d5_reg;
            tose_pkg::SRC_P:  b_val = p_reg;
            tose_pkg::SRC_T:  b_val = t_reg;
            tose_pkg::SRC_H:  b_val = h_ext;
            tose_pkg::SRC_H2: b_val = h_ext >> 1;
            tose_pkg::SRC_H3: b_val = h3_reg;
            tose_pkg::SRC_H4: b_val = h_ext >> 2;
            tose_pkg::SRC_H5: b_val = h5_reg;
            tose_pkg::SRC_R3: b_val = tose_pkg::RECIP3;
            tose_pkg::SRC_R5: b_val = tose_pkg::RECIP5;
            default:          b_val = '0;
        endcase
    end

    // Saturating add: clamp to the 64-bit range on signed overflow.
    always_comb begin
        add_sum = {a_val[AW-1], a_val} + {b_val[AW-1], b_val};
        add_ov  = add_sum[AW] != add_sum[AW-1];
        add_res = add_ov ? (a_val[AW-1] ? tose_pkg::ACC_MIN : tose_pkg::ACC_MAX)
                         : add_sum[AW-1:0];
    end

    // Final clamp of x to 48 bits, sign-extended back to the working width.
    always_comb begin
        clamp_ov  = !((&a_val[AW-1:VW-1]) || !(|a_val[AW-1:VW-1]));
        clamp_res = clamp_ov ? (a_val[AW-1] ? {{(AW-VW+1){1'b1}}, {(VW-1){1'b0}}}
                                            : {{(AW-VW+1){1'b0}}, {(VW-1){1'b1}}})
                             : a_val;
    end

    // Time: start + count*h, aligned to the fraction bits, clamped to 48 bits.
    always_comb begin
        t_scaled = (TW'(kh_reg) << UP) >> DN;
        t_sum    = {{(TW-VW){start_time_reg[VW-1]}}, start_time_reg} + t_scaled;
        t_ov     = !((&t_sum[TW-1:VW-1]) || !(|t_sum[TW-1:VW-1]));
        t_res    = t_ov ? (t_sum[TW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}})
                        : t_sum[VW-1:0];
    end

    // Microcode program counter: advance, jump, or hold while waiting on the multiplier or output.
    always_comb begin
        pc_next = pc_reg;
        case (uw.op)
            tose_pkg::OP_BRST: pc_next = restart_reg ? uw.target : pc_reg + 1'b1;
            tose_pkg::OP_JMP:  pc_next = uw.target;
            tose_pkg::OP_MUL:  pc_next = mul_take ? pc_reg + 1'b1 : pc_reg;
            tose_pkg::OP_EMIT: pc_next = pc_reg;
            default:           pc_next = pc_reg + 1'b1;
        endcase
    end

    assign mreq.start = mul_fire;
    assign mreq.sh    = uw.sh;
    assign mreq.k     = uw.k;

    tose_mul #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .a       (a_val),
        .b       (b_val),
        .rsp     (mrsp),
        .result  (mul_res)
    );

    // Control, configuration and solution state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg     <= tose_pkg::STEP_SIZE_RST;
            start_time_reg    <= tose_pkg::START_TIME_RST;
            initial_value_reg <= tose_pkg::INITIAL_VALUE_RST;
            v_reg             <= {{(AW-VW){tose_pkg::INITIAL_VALUE_RST[VW-1]}},
                                  tose_pkg::INITIAL_VALUE_RST};
            count_reg         <= '0;
            busy_reg          <= 1'b0;
            pc_reg            <= '0;
            restart_reg       <= 1'b0;
            pend_reg          <= 1'b0;
            hit_reg           <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    tose_pkg::REG_STEP_SIZE:     step_size_reg     <= cfg_wr_data[HB-1:0];
                    tose_pkg::REG_START_TIME:    start_time_reg    <= cfg_wr_data[VW-1:0];
                    tose_pkg::REG_INITIAL_VALUE: initial_value_reg <= cfg_wr_data[VW-1:0];
                    default: ;
                endcase
            end

            // drop the result once taken; a new one may load in the same cycle
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (accept) begin
                busy_reg    <= 1'b1;
                pc_reg      <= '0;
                restart_reg <= s_restart;
                hit_reg     <= 1'b0;
                pend_reg    <= 1'b0;
            end else if (busy_reg) begin
                pc_reg <= pc_next;
                if (mul_fire) begin
                    pend_reg <= 1'b1;
                end
                if (mul_take) begin
                    pend_reg <= 1'b0;
                    hit_reg  <= hit_reg | mrsp.sat;
                end
                if (add_do && add_ov) begin
                    hit_reg <= 1'b1;
                end
                case (uw.op)
                    tose_pkg::OP_LOAD: begin
                        v_reg     <= {{(AW-VW){initial_value_reg[VW-1]}}, initial_value_reg};
                        count_reg <= '0;
                    end
                    tose_pkg::OP_CLAMP: begin
                        v_reg <= clamp_res;
                        if (clamp_ov) begin
                            hit_reg <= 1'b1;
                        end
                        // hold the count at its maximum
                        if (count_reg != COUNT_MAX) begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (emit_do) begin
                    m_valid_reg <= 1'b1;
                    busy_reg    <= 1'b0;
                end
            end
        end
    end

    // Working registers and result payload.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            case (uw.dst)
                tose_pkg::DST_T:  t_reg  <= wr_data;
                tose_pkg::DST_P:  p_reg  <= wr_data;
                tose_pkg::DST_D1: d1_reg <= wr_data;
                tose_pkg::DST_D2: d2_reg <= wr_data;
                tose_pkg::DST_D3: d3_reg <= wr_data;
                tose_pkg::DST_D4: d4_reg <= wr_data;
                tose_pkg::DST_D5: d5_reg <= wr_data;
                tose_pkg::DST_H3: h3_reg <= wr_data;
                tose_pkg::DST_H5: h5_reg <= wr_data;
                default: ;
            endcase
        end
        if (busy_reg && uw.op == tose_pkg::OP_TIME) begin
            kh_reg <= KH_W'(count_reg) * KH_W'(step_size_reg);
        end
        if (emit_do) begin
            m_step_index     <= tose_pkg::STEP_INDEX_W'(count_reg);
            m_time_value     <= t_res;
            m_solution_value <= v_reg[VW-1:0];
            m_overflow       <= hit_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ sim/taylor_step_checker.sv @@
// Step checker for the Taylor ODE step engine: tracks the register writes, predicts each
// result word from the accepted input words and compares it with the result channel.
// Depends on tose_pkg for widths, register indexes and reset values.
module taylor_step_checker
    import tose_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_wr_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_restart,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [STEP_INDEX_W-1:0]       m_step_index,
    input  logic signed [VAL_W-1:0]       m_time_value,
    input  logic signed [VAL_W-1:0]       m_solution_value,
    input  logic                          m_overflow,
    output int                            fail_count,
    output int                            pending
);

    localparam int WIDE_W = 2 * ACC_W;
    localparam int FRAC_BITS = 32;
    localparam logic [STEP_INDEX_W-1:0] COUNT_MAX = '1;

    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef struct packed {
        logic [STEP_INDEX_W-1:0] step_index;
        logic signed [VAL_W-1:0] time_value;
        logic signed [VAL_W-1:0] solution_value;
        logic                    overflow;
    } step_result_t;

    logic [H_BITS-1:0]       step_h;
    logic signed [VAL_W-1:0] start_t;
    logic signed [VAL_W-1:0] init_x;
    logic signed [VAL_W-1:0] cur_x;
    logic [STEP_INDEX_W-1:0] step_cnt;
    bit                      sat_seen;
    step_result_t            expected_steps[$];

    // Clip a wide value into the 64-bit intermediate and note any saturation.
    function automatic acc_t fit64(input wide_t x);
        if (x[WIDE_W-1:ACC_W-1] != {(ACC_W+1){x[ACC_W-1]}}) begin
            sat_seen = 1'b1;
            return x[WIDE_W-1] ? ACC_MIN : ACC_MAX;
        end
        return x[ACC_W-1:0];
    endfunction

    function automatic acc_t add_sat(input acc_t a, input acc_t b);
        wide_t s;
        s = a;
        s = s + b;
        return fit64(s);
    endfunction

    // Exact product, arithmetic shift (floor), then saturate.
    function automatic acc_t mul_shift(input acc_t a, input acc_t b, input int sh);
        wide_t p;
        p = a;
        p = p * b;
        p = p >>> sh;
        return fit64(p);
    endfunction

    function automatic acc_t fmul(input acc_t a, input acc_t b);
        return mul_shift(a, b, FRAC_BITS);
    endfunction

    function automatic acc_t scale(input acc_t a, input int k);
        wide_t p;
        p = a;
        p = p * k;
        return fit64(p);
    endfunction

    function automatic acc_t times_h(input acc_t a, input logic [H_BITS-1:0] hk);
        acc_t hw;
        hw = {{(ACC_W-H_BITS){1'b0}}, hk};
        return mul_shift(a, hw, H_BITS);
    endfunction

    function automatic logic signed [VAL_W-1:0] clamp48(input acc_t v, output bit hit);
        hit = 1'b0;
        if (v[ACC_W-1:VAL_W-1] != {(ACC_W-VAL_W+1){v[VAL_W-1]}}) begin
            hit = 1'b1;
            return v[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
        return v[VAL_W-1:0];
    endfunction

    // Advance x by one order-5 Taylor step, or reload it, and form the result word.
    function automatic step_result_t predict_taylor_step(input logic restart);
        acc_t         v, d1, d2, d3, d4, d5, p, t;
        logic [63:0]  kh;
        bit           hit;
        step_result_t r;
        sat_seen = 1'b0;
        if (restart) begin
            cur_x    = init_x;
            step_cnt = '0;
        end else begin
            v  = cur_x;
            d1 = add_sat(v, fmul(v, v));
            d2 = add_sat(d1, scale(fmul(v, d1), 2));
            d3 = add_sat(add_sat(d2, scale(fmul(v, d2), 2)), scale(fmul(d1, d1), 2));
            d4 = add_sat(add_sat(d3, scale(fmul(v, d3), 2)), scale(fmul(d1, d2), 6));
            d5 = add_sat(add_sat(d4, scale(fmul(v, d4), 2)),
                         add_sat(scale(fmul(d2, d2), 6), scale(fmul(d1, d3), 8)));
            p  = add_sat(d4, times_h(d5, step_h / 5));
            p  = add_sat(d3, times_h(p, step_h / 4));
            p  = add_sat(d2, times_h(p, step_h / 3));
            p  = add_sat(d1, times_h(p, step_h / 2));
            v  = add_sat(v, times_h(p, step_h));
            cur_x = clamp48(v, hit);
            if (hit)
                sat_seen = 1'b1;
            if (step_cnt != COUNT_MAX)
                step_cnt = step_cnt + 1'b1;
        end
        // time never raises the flag
        kh = step_cnt;
        kh = kh * step_h;
        t  = start_t;
        t  = t + kh;
        r.time_value     = clamp48(t, hit);
        r.step_index     = step_cnt;
        r.solution_value = cur_x;
        r.overflow       = sat_seen;
        return r;
    endfunction

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge aclk) begin
        step_result_t want;
        if (!aresetn) begin
            step_h   = STEP_SIZE_RST;
            start_t  = START_TIME_RST;
            init_x   = INITIAL_VALUE_RST;
            cur_x    = INITIAL_VALUE_RST;
            step_cnt = '0;
            expected_steps.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_STEP_SIZE:     step_h  = cfg_wr_data[H_BITS-1:0];
                    REG_START_TIME:    start_t = cfg_wr_data;
                    REG_INITIAL_VALUE: init_x  = cfg_wr_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_steps.push_back(predict_taylor_step(s_restart));
            if (m_valid && m_ready) begin
                if (expected_steps.size() == 0) begin
                    $error("result word with no step outstanding");
                    fail_count++;
                end else begin
                    want = expected_steps.pop_front();
                    if (m_step_index !== want.step_index) begin
                        $error("step_index: expected %0d, got %0d",
                               want.step_index, m_step_index);
                        fail_count++;
                    end
                    if (m_time_value !== want.time_value) begin
                        $error("time_value: expected %0d, got %0d",
                               want.time_value, m_time_value);
                        fail_count++;
                    end
                    if (m_solution_value !== want.solution_value) begin
                        $error("solution_value: expected %0d, got %0d",
                               want.solution_value, m_solution_value);
                        fail_count++;
                    end
                    if (m_overflow !== want.overflow) begin
                        $error("overflow: expected %0d, got %0d",
                               want.overflow, m_overflow);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_steps.size();
    end

endmodule

@@ sim/tb_top.sv @@
// Top of the Taylor ODE step engine bench: clock, reset, register writes, input words
// and result back-pressure; the checker beside the block does all prediction.
// Depends on tose_pkg, taylor_ode_step_engine and taylor_step_checker.
module tb_top;
    import tose_pkg::*;

    localparam logic [VAL_W-1:0] MAX48     = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] MIN48     = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] MINUS_ONE = 48'hFFFF_0000_0000;  // -1.0 in Q16.32
    localparam logic [VAL_W-1:0] ONE_HALF  = 48'h0000_8000_0000;  // 0.5 in Q16.32
    localparam int RANDOM_PHASES  = 12;
    localparam int WORDS_PER_PHASE = 105;
    localparam int LONG_HOLD      = 1500;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_wr_data;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_restart;
    logic                          m_valid;
    logic                          m_ready;
    logic [STEP_INDEX_W-1:0]       m_step_index;
    logic signed [VAL_W-1:0]       m_time_value;
    logic signed [VAL_W-1:0]       m_solution_value;
    logic                          m_overflow;
    int                            fail_count;
    int                            pending;

    // Shared between the word source and the result sink.
    bit calm;       // no idling on either side
    bit hold_req;   // ask the sink for one long hold-off

    taylor_ode_step_engine dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_restart        (s_restart),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_step_index     (m_step_index),
        .m_time_value     (m_time_value),
        .m_solution_value (m_solution_value),
        .m_overflow       (m_overflow)
    );

    taylor_step_checker step_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_restart        (s_restart),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_step_index     (m_step_index),
        .m_time_value     (m_time_value),
        .m_solution_value (m_solution_value),
        .m_overflow       (m_overflow),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hard stop; ends the run with a failure if it has not finished by then.
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Offer one word. Drop valid only when an idle gap follows, so valid is never
    // lowered and raised in the same step; hold the payload until accepted.
    task automatic send_word(input logic restart);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(0, 99) < 29)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Wait for the block to drain, then write all three registers back to back.
    // Junk above bit 31 of the step size must be ignored.
    task automatic load_config(input logic [H_BITS-1:0] h, input logic [VAL_W-1:0] t0,
                               input logic [VAL_W-1:0] x0);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_STEP_SIZE;
        cfg_wr_data <= {16'($urandom()), h};
        @(posedge aclk);
        cfg_index   <= REG_START_TIME;
        cfg_wr_data <= t0;
        @(posedge aclk);
        cfg_index   <= REG_INITIAL_VALUE;
        cfg_wr_data <= x0;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Result sink: random stalls, plus one long hold-off per request so the block
    // fills up and the source sees s_ready low for a long stretch.
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= 29);
            end
        end
    end

    // Word source and verdict.
    initial begin
        logic [H_BITS-1:0] h;
        logic [VAL_W-1:0]  t0;
        logic [VAL_W-1:0]  x0;
        bit                first_restart;
        calm        = 1'b0;
        hold_req    = 1'b0;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= REG_STEP_SIZE;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_restart   <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values: tick from the reset x, then restart and tick again.
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b0);

        // Zero step, largest x: the higher derivatives overflow even though x cannot move.
        load_config('0, MIN48, MAX48);
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b0);

        // Largest step, start near the top: time saturates; x = -1 is a fixed point.
        load_config('1, MAX48 - 48'd1, MINUS_ONE);
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b0);

        // Most negative x and start time.
        load_config('1, MIN48, MIN48);
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b0);

        // x = 0 stays at zero.
        load_config(32'h0100_0000, '0, '0);
        send_word(1'b1);
        send_word(1'b0);

        // A new initial value waits for the next restart: tick first from x = 0.
        load_config(32'h0080_0000, '0, ONE_HALF);
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b0);

        // Random phases: mostly small steps and moderate x so that runs of ticks
        // go deep before saturating, with the extremes mixed in.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 9))
                0:       h = '0;
                1:       h = '1;
                2, 3:    h = $urandom();
                default: h = $urandom_range(32'h0001_0000, 32'h0800_0000);
            endcase
            case ($urandom_range(0, 5))
                0:       t0 = MIN48;
                1:       t0 = MAX48;
                default: t0 = $signed({16'($urandom()), $urandom()}) >>> $urandom_range(0, 16);
            endcase
            case ($urandom_range(0, 11))
                0:       x0 = MIN48;
                1:       x0 = MAX48;
                2:       x0 = '0;
                3:       x0 = MINUS_ONE;
                4:       x0 = {16'($urandom()), $urandom()};
                default: x0 = $signed({16'($urandom()), $urandom()}) >>> $urandom_range(14, 16);
            endcase
            load_config(h, t0, x0);
            calm = (ph == 5);
            if (ph == 3 || ph == 9)
                hold_req = 1'b1;
            // Usually restart into the new initial value; sometimes carry x over.
            first_restart = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < WORDS_PER_PHASE; i++)
                send_word((i == 0 && first_restart) || ($urandom_range(0, 99) < 8));
        end

        // Drain, let the block settle, then give the verdict.
        s_valid <= 1'b0;
        calm = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
src/tose_pkg.sv
src/tose_mul.sv
src/taylor_ode_step_engine.sv
sim/taylor_step_checker.sv
sim/tb_top.sv
